// ===== rtl/core/bsm_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_pkg
// Shared types and constants for the radix-2 Booth multiplier bit-cell row.
// ----------------------------------------------------------------------------
package bsm_pkg;

  localparam int MAX_BITS  = 32;
  localparam int MIN_BITS  = 2;
  localparam int W_BITS    = $clog2(MAX_BITS + 1);
  localparam int PROD_BITS = 2 * MAX_BITS;
  localparam logic [W_BITS-1:0] RESET_BITS = W_BITS'(16);

  // Booth recoding of the scanned bit pair
  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_ADD  = 2'd1,
    OP_SUB  = 2'd2
  } booth_op_t;

  // Control broadcast to every cell of the row
  typedef struct packed {
    logic      load;
    logic      step;
    booth_op_t op;
  } cell_ctl_t;

endpackage : bsm_pkg
`default_nettype wire

// ===== rtl/core/booth_signed_multiplier.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// booth_signed_multiplier
// Radix-2 Booth multiplier of two signed operands at a configurable width,
// built as a row of bit cells that shift right by one each step.
// ----------------------------------------------------------------------------
// An item is loaded, then takes one Booth add/subtract-and-shift step per
// operand bit through the 32-cell row (operand_bits clamped to 2..32, with
// a reset width of 16), and then its result moves into the output register.
// An item with an operand outside the width skips the steps and yields a
// zero product with range_error set. One item is in the row at a time; the
// next item is taken as soon as the previous result has moved to the output
// register, even if that result is still stalled there. operand_bits is
// written through the cfg port, always ready; the user must write it only
// while the block is idle, and the block itself does not enforce this.
// ----------------------------------------------------------------------------
module booth_signed_multiplier (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       in_valid,
  output logic                            in_stall,
  input  wire logic signed [31:0]         in_multiplier,
  input  wire logic signed [31:0]         in_multiplicand,
  output logic                            out_valid,
  input  wire logic                       out_stall,
  output logic signed [63:0]              out_product,
  output logic                            out_range_error,
  input  wire logic                       cfg_valid,
  output logic                            cfg_ready,
  input  wire logic [5:0]                 cfg_data
);
  import bsm_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_RUN
  } state_t;

  state_t                     state_r;
  logic [W_BITS-1:0]          operand_bits_r;
  logic [W_BITS-1:0]          cnt_r;
  logic                       q1_r;
  logic                       err_r;
  logic                       out_valid_r;
  logic signed [PROD_BITS-1:0] out_product_r;
  logic                       out_range_error_r;

  logic [W_BITS-1:0]          n_eff;
  logic                       accept;
  logic                       bad_op;
  logic                       finish;
  cell_ctl_t                  ctl;

  logic [MAX_BITS-1:0]        active;
  logic [MAX_BITS-1:0]        top;
  logic [MAX_BITS-1:0]        carry;
  logic [MAX_BITS-1:0]        ext;
  logic [MAX_BITS-1:0]        a_new;
  logic [MAX_BITS-1:0]        a_bits;
  logic [MAX_BITS-1:0]        q_bits;
  logic [PROD_BITS-1:0]       prod;

  // effective width
  always_comb begin
    priority if (operand_bits_r < W_BITS'(MIN_BITS)) n_eff = W_BITS'(MIN_BITS);
    else if (operand_bits_r > W_BITS'(MAX_BITS))     n_eff = W_BITS'(MAX_BITS);
    else                                             n_eff = operand_bits_r;
  end

  // two's-complement range check: bits from n-1 upward must match the sign
  always_comb begin
    bad_op = 1'b0;
    for (int i = 0; i < MAX_BITS; i++) begin
      if (W_BITS'(i + 1) >= n_eff) begin
        if (in_multiplier[i] != in_multiplier[MAX_BITS-1])
          bad_op = 1'b1;
        if (in_multiplicand[i] != in_multiplicand[MAX_BITS-1])
          bad_op = 1'b1;
      end
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign accept    = in_valid && !in_stall;
  assign cfg_ready = 1'b1;
  assign finish    = (state_r == S_RUN) && (err_r || (cnt_r == n_eff)) &&
                     (!out_valid_r || !out_stall);

  always_comb begin
    ctl.load = accept;
    ctl.step = (state_r == S_RUN) && !err_r && (cnt_r != n_eff);
    priority if (q_bits[0] && !q1_r)  ctl.op = OP_SUB;
    else if (!q_bits[0] && q1_r)      ctl.op = OP_ADD;
    else                              ctl.op = OP_NONE;
  end

  // row of bit cells
  for (genvar i = 0; i < MAX_BITS; i++) begin : g_cell
    logic cin;
    logic ein;
    logic aup;
    logic qup;

    if (i == 0) begin : g_lo
      assign cin = (ctl.op == OP_SUB);
      assign ein = 1'b0;
    end else begin : g_mid
      assign cin = carry[i-1];
      assign ein = ext[i-1];
    end

    if (i == MAX_BITS - 1) begin : g_hi
      assign aup = a_new[i];   // arithmetic shift keeps the sign
      assign qup = 1'b0;
    end else begin : g_dn
      assign aup = a_new[i+1];
      assign qup = q_bits[i+1];
    end

    assign active[i] = (W_BITS'(i) < n_eff);
    assign top[i]    = (W_BITS'(i + 1) == n_eff);

    bsm_cell u_cell (
      .clk     (clk),
      .ctl     (ctl),
      .active  (active[i]),
      .top     (top[i]),
      .ld_q    (in_multiplier[i] & active[i]),
      .ld_m    (in_multiplicand[i]),
      .carry_i (cin),
      .ext_i   (ein),
      .a_up    (aup),
      .q_up    (qup),
      .a0_new  (a_new[0]),
      .carry_o (carry[i]),
      .ext_o   (ext[i]),
      .a_new_o (a_new[i]),
      .a_o     (a_bits[i]),
      .q_o     (q_bits[i])
    );
  end

  // accumulator is held sign extended, multiplier bits above the width are 0
  assign prod = ({{MAX_BITS{a_bits[MAX_BITS-1]}}, a_bits} << n_eff) |
                {{MAX_BITS{1'b0}}, q_bits};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r        <= S_IDLE;
      operand_bits_r <= RESET_BITS;
      cnt_r          <= '0;
      q1_r           <= 1'b0;
      err_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready)
        operand_bits_r <= cfg_data;

      // drop the output item once taken, unless a new one replaces it
      if (out_valid_r && !out_stall && !finish)
        out_valid_r <= 1'b0;

      unique case (state_r)
        S_IDLE: begin
          if (accept) begin
            state_r <= S_RUN;
            cnt_r   <= '0;
            q1_r    <= 1'b0;
            err_r   <= bad_op;
          end
        end
        S_RUN: begin
          if (ctl.step) begin
            cnt_r <= cnt_r + W_BITS'(1);
            q1_r  <= q_bits[0];
          end else if (finish) begin
            out_valid_r       <= 1'b1;
            out_product_r     <= err_r ? '0 : prod;
            out_range_error_r <= err_r;
            state_r           <= S_IDLE;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_product     = out_product_r;
  assign out_range_error = out_range_error_r;

endmodule : booth_signed_multiplier
`default_nettype wire

// ===== rtl/core/bsm_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// bsm_cell
// One bit slice of the Booth datapath: accumulator, multiplier and
// multiplicand bits, a full adder, and the right-shift hand-off to the
// lower neighbor.
// ----------------------------------------------------------------------------
module bsm_cell (
  input  wire logic              clk,
  input  wire bsm_pkg::cell_ctl_t ctl,
  input  wire logic              active,   // bit lies inside the operand width
  input  wire logic              top,      // most significant bit of the width
  input  wire logic              ld_q,
  input  wire logic              ld_m,
  input  wire logic              carry_i,
  input  wire logic              ext_i,    // sign of the sum from below
  input  wire logic              a_up,     // upper neighbor's new accumulator bit
  input  wire logic              q_up,     // upper neighbor's multiplier bit
  input  wire logic              a0_new,   // new accumulator bit 0
  output logic                   carry_o,
  output logic                   ext_o,
  output logic                   a_new_o,
  output logic                   a_o,
  output logic                   q_o
);
  import bsm_pkg::*;

  logic a_r, a_nxt;
  logic q_r, q_nxt;
  logic m_r, m_nxt;
  logic b;
  logic s;

  always_comb begin
    unique case (ctl.op)
      OP_ADD:  b = m_r;
      OP_SUB:  b = ~m_r;
      default: b = 1'b0;
    endcase
    s       = a_r ^ b ^ carry_i;
    carry_o = (a_r & b) | (a_r & carry_i) | (b & carry_i);
    // bits above the width copy the sign of the wrapped sum
    a_new_o = active ? s : ext_i;
    ext_o   = a_new_o;
  end

  always_comb begin
    a_nxt = a_r;
    q_nxt = q_r;
    m_nxt = m_r;
    if (ctl.load) begin
      a_nxt = 1'b0;
      q_nxt = ld_q;
      m_nxt = ld_m;
    end else if (ctl.step) begin
      a_nxt = a_up;
      q_nxt = active ? (top ? a0_new : q_up) : 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    a_r <= a_nxt;
    q_r <= q_nxt;
    m_r <= m_nxt;
  end

  assign a_o = a_r;
  assign q_o = q_r;

endmodule : bsm_cell
`default_nettype wire

// ===== bench/booth_signed_multiplier_tb.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// booth_signed_multiplier_tb
// Self-checking bench for the radix-2 Booth multiplier. A queue of operand
// pairs feeds a clocked driver, and a clocked monitor compares every product
// and range flag against a bit-accurate Booth model kept in the bench. The
// operand width is swept across the clamped extremes and random settings
// between drained phases. Both channels idle at random, and one long output
// stall backs the block up into its input.
// ----------------------------------------------------------------------------
module booth_signed_multiplier_tb;
  import bsm_pkg::*;

  localparam int CYCLE_LIMIT = 600000;
  localparam int ITEM_GOAL   = 1600;
  localparam int HOLD_AT     = 200;
  localparam int HOLD_LEN    = 400;
  localparam logic [W_BITS-1:0] SWEEP [9] = '{
    W_BITS'(2), W_BITS'(0), W_BITS'(1), W_BITS'(32), W_BITS'(63),
    W_BITS'(33), W_BITS'(3), W_BITS'(31), W_BITS'(16)
  };

  typedef struct packed {
    logic signed [31:0] multiplier;
    logic signed [31:0] multiplicand;
  } operand_pair_t;

  typedef struct packed {
    logic signed [63:0] product;
    logic               range_error;
  } booth_result_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic signed [31:0]       in_multiplier = '0;
  logic signed [31:0]       in_multiplicand = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic signed [63:0]       out_product;
  logic                     out_range_error;
  logic                     cfg_valid = 1'b0;
  logic                     cfg_ready;
  logic [W_BITS-1:0]        cfg_data = '0;

  // width register as the bench believes it to be
  logic [W_BITS-1:0]        width_reg = RESET_BITS;

  operand_pair_t            operand_q [$];
  booth_result_t            product_q [$];

  int                       n_queued = 0;
  int                       n_accepted = 0;
  int                       n_checked = 0;
  int                       n_fail = 0;
  int                       n_cycles = 0;
  int                       hold_cnt = 0;
  logic                     hold_armed = 1'b1;
  int unsigned              tx_gap = 0;
  int unsigned              rx_wait = 0;
  logic                     tx_calm = 1'b0;
  logic                     rx_calm = 1'b0;

  booth_signed_multiplier u_top (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_multiplier   (in_multiplier),
    .in_multiplicand (in_multiplicand),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_product     (out_product),
    .out_range_error (out_range_error),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int unsigned eff_width(input logic [W_BITS-1:0] wreg);
    int unsigned n;
    n = 32'(wreg);
    if (n < MIN_BITS) n = MIN_BITS;
    if (n > MAX_BITS) n = MAX_BITS;
    return n;
  endfunction

  // Booth scan of A:Q:q1 at the effective width, A wrapping at that width
  function automatic booth_result_t booth_product(input logic [W_BITS-1:0] wreg,
                                                  input logic signed [31:0] mr,
                                                  input logic signed [31:0] md);
    booth_result_t res;
    int unsigned   n;
    int unsigned   i;
    longint        hi;
    longint        lo;
    logic [63:0]   mask;
    logic [63:0]   top;
    logic [63:0]   a;
    logic [63:0]   q;
    logic [63:0]   m;
    logic [63:0]   p;
    logic [63:0]   pmask;
    logic          q1;
    logic          b;
    n = eff_width(wreg);
    hi = (longint'(1) <<< (n - 1)) - 1;
    lo = -hi - 1;
    res.product = '0;
    res.range_error = 1'b1;
    if (longint'(mr) < lo || longint'(mr) > hi || longint'(md) < lo || longint'(md) > hi)
      return res;
    mask = (64'd1 << n) - 64'd1;
    top = 64'd1 << (n - 1);
    a = '0;
    q1 = 1'b0;
    q = 64'(longint'(mr)) & mask;
    m = 64'(longint'(md)) & mask;
    for (i = 0; i < n; i++) begin
      b = q[0];
      if (b && !q1) a = (a - m) & mask;
      else if (!b && q1) a = (a + m) & mask;
      q1 = b;
      q = (q >> 1) | (64'(a[0]) << (n - 1));
      a = (a >> 1) | (a & top);
    end
    p = (a << n) | q;
    if (2 * n < 64) begin
      pmask = (64'd1 << (2 * n)) - 64'd1;
      p = p & pmask;
      if (p[2 * n - 1]) p = p | ~pmask;
    end
    res.product = p;
    res.range_error = 1'b0;
    return res;
  endfunction

  // mostly in-range values, some width boundaries, some raw 32-bit noise
  function automatic logic signed [31:0] pick_operand(input int unsigned n);
    logic signed [31:0] v;
    logic signed [31:0] lo;
    lo = 32'sh8000_0000 >>> (32 - n);
    case ($urandom_range(0, 9))
      0: v = $urandom;
      1: begin
        case ($urandom_range(0, 5))
          0: v = lo;
          1: v = ~lo;
          2: v = '0;
          3: v = -32'sd1;
          4: v = lo - 32'sd1;
          default: v = ~lo + 32'sd1;
        endcase
      end
      default: begin
        v = $urandom;
        v = v << (32 - n);
        v = v >>> (32 - n);
      end
    endcase
    return v;
  endfunction

  task automatic add_pair(input logic signed [31:0] mr, input logic signed [31:0] md);
    operand_pair_t pair;
    pair.multiplier = mr;
    pair.multiplicand = md;
    operand_q.insert(operand_q.size(), pair);
    n_queued++;
  endtask

  task automatic add_random(input int count);
    int unsigned n;
    n = eff_width(width_reg);
    repeat (count) add_pair(pick_operand(n), pick_operand(n));
  endtask

  // hold off until every queued item has been accepted and checked
  task automatic wait_idle();
    do @(posedge clk);
    while (n_accepted != n_queued || n_checked != n_accepted);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_width(input logic [W_BITS-1:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk);
    while (!cfg_ready);
    cfg_valid <= 1'b0;
    width_reg = v;
  endtask

  // driver: present the next pair once the current one is taken
  always @(posedge clk) begin : driver
    logic          fire;
    logic          next_valid;
    operand_pair_t nxt;
    if (!rst_n) begin
      in_valid <= 1'b0;
      tx_gap = 0;
    end else begin
      fire = in_valid && !in_stall;
      next_valid = in_valid && !fire;
      if (fire) begin
        product_q.insert(product_q.size(),
                         booth_product(width_reg, in_multiplier, in_multiplicand));
        n_accepted <= n_accepted + 1;
        if ($urandom_range(0, 63) == 0) tx_calm = !tx_calm;
        tx_gap = tx_calm ? 0 : $urandom_range(0, 3);
      end
      if (!next_valid) begin
        if (tx_gap > 0) begin
          tx_gap--;
        end else if (operand_q.size() > 0) begin
          nxt = operand_q.pop_front();
          in_multiplier <= nxt.multiplier;
          in_multiplicand <= nxt.multiplicand;
          next_valid = 1'b1;
        end
      end
      in_valid <= next_valid;
    end
  end

  // one long output stall, so the row and output register both fill
  always @(posedge clk) begin
    if (!rst_n) begin
      hold_cnt <= 0;
      hold_armed <= 1'b1;
    end else if (hold_armed && n_accepted >= HOLD_AT) begin
      hold_cnt <= HOLD_LEN;
      hold_armed <= 1'b0;
    end else if (hold_cnt > 0) begin
      hold_cnt <= hold_cnt - 1;
    end
  end

  // monitor: compare each accepted result with the oldest prediction
  always @(posedge clk) begin : monitor
    booth_result_t want;
    int unsigned   wait_n;
    if (!rst_n) begin
      out_stall <= 1'b0;
      rx_wait = 0;
    end else begin
      wait_n = rx_wait;
      if (out_valid && !out_stall) begin
        if (product_q.size() == 0) begin
          $error("unexpected result: product %0d range_error %0b",
                 out_product, out_range_error);
          n_fail <= n_fail + 1;
        end else begin
          want = product_q.pop_front();
          if (out_product !== want.product || out_range_error !== want.range_error) begin
            if (out_product !== want.product)
              $error("product: expected %0d, actual %0d", want.product, out_product);
            if (out_range_error !== want.range_error)
              $error("range_error: expected %0b, actual %0b",
                     want.range_error, out_range_error);
            n_fail <= n_fail + 1;
          end
        end
        n_checked <= n_checked + 1;
        if ($urandom_range(0, 63) == 0) rx_calm = !rx_calm;
        wait_n = rx_calm ? 0 : $urandom_range(0, 3);
      end else if (wait_n > 0) begin
        wait_n--;
      end
      rx_wait = wait_n;
      out_stall <= (wait_n > 0) || (hold_cnt > 0);
    end
  end

  always @(posedge clk) begin
    n_cycles <= n_cycles + 1;
    if (n_cycles >= CYCLE_LIMIT) begin
      $display("booth_signed_multiplier test failed");
      $finish;
    end
  end

  initial begin : stimulus
    logic [W_BITS-1:0] w;
    int                k;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;

    // reset width of 16: full-scale corners and just-outside operands
    add_pair(32'sd0, 32'sd0);
    add_pair(32'sd32767, 32'sd32767);
    add_pair(-32'sd32768, -32'sd32768);
    add_pair(-32'sd32768, 32'sd32767);
    add_pair(32'sd32767, -32'sd32768);
    add_pair(-32'sd1, -32'sd1);
    add_pair(32'sd1, -32'sd1);
    add_pair(32'sd5, -32'sd32768);
    add_pair(32'sd21845, -32'sd21846);
    add_pair(32'sd32768, 32'sd1);
    add_pair(-32'sd32769, 32'sd1);
    add_pair(32'sd1, 32'sd32768);
    add_pair(32'sd1, -32'sd32769);
    add_pair(32'sh7FFF_FFFF, 32'sh8000_0000);
    add_pair(32'sh8000_0000, 32'sh7FFF_FFFF);
    wait_idle();

    // width sweep, clamped settings included
    for (k = 0; k < 9; k++) begin
      write_width(SWEEP[k]);
      if (SWEEP[k] == W_BITS'(32)) begin
        add_pair(32'sh8000_0000, 32'sh8000_0000);
        add_pair(32'sh7FFF_FFFF, 32'sh8000_0000);
        add_pair(32'sh8000_0000, 32'sh7FFF_FFFF);
        add_pair(32'sh7FFF_FFFF, 32'sh7FFF_FFFF);
        add_pair(-32'sd1, 32'sh8000_0000);
      end
      add_random(40);
      wait_idle();
    end

    // random widths, biased toward narrow ones to keep items short
    while (n_queued < ITEM_GOAL) begin
      if ($urandom_range(0, 3) != 0) w = W_BITS'($urandom_range(2, 12));
      else w = W_BITS'($urandom_range(0, 63));
      write_width(w);
      add_random($urandom_range(20, 60));
      wait_idle();
    end

    repeat (40) @(posedge clk);
    if (n_fail == 0 && product_q.size() == 0) begin
      $display("booth_signed_multiplier test passed");
    end else begin
      $display("booth_signed_multiplier test failed");
    end
    $finish;
  end

endmodule : booth_signed_multiplier_tb
`default_nettype wire
